// ----- rtl/stc_pkg.sv -----
// shared types and constants for the sphere triangle contact core
package stc_pkg;

    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } t_region;

    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// ----- rtl/stc_if.sv -----
// query and result channel interfaces of the sphere triangle contact core
interface stc_in_if #(parameter int COORD_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic [3*COORD_WIDTH-1:0]          sphere_center;
    logic [COORD_WIDTH-2:0]            sphere_radius;
    logic [3*COORD_WIDTH-1:0]          vertex_a;
    logic [3*COORD_WIDTH-1:0]          vertex_b;
    logic [3*COORD_WIDTH-1:0]          vertex_c;
    logic [3*stc_pkg::NORM_W-1:0]      face_normal;

    modport source (
        output valid, sphere_center, sphere_radius, vertex_a, vertex_b, vertex_c,
               face_normal,
        input  ready
    );
    modport sink (
        input  valid, sphere_center, sphere_radius, vertex_a, vertex_b, vertex_c,
               face_normal,
        output ready
    );
endinterface

interface stc_out_if #(parameter int COORD_WIDTH = 16);
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [3*COORD_WIDTH-1:0] closest_point;
    logic [3*COORD_WIDTH-1:0] push_vector;
    logic [2:0]               region;

    modport source (output valid, hit, closest_point, push_vector, region, input ready);
    modport sink (input valid, hit, closest_point, push_vector, region, output ready);
endinterface

// ----- rtl/stc_div.sv -----
// pipelined three lane restoring divider with shared divisor and sideband
module stc_div #(
    parameter int RW     = 112,
    parameter int DNW    = 75,
    parameter int QB     = 18,
    parameter int SIDE_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stc_pkg::t_stage_ctl       i_ctl,
    input  logic [2:0][RW-1:0]        i_num,
    input  logic [DNW-1:0]            i_den,
    input  logic [2:0]                i_neg,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [2:0][QB:0]          o_quot,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int XW = RW + QB + 1;

    logic [2:0][XW-1:0]  r_rem  [QB+1];
    logic [2:0][QB-1:0]  r_q    [QB+1];
    logic [XW-1:0]       r_d    [QB+1];
    logic [2:0]          r_neg  [QB+1];
    logic [2:0]          r_ovf  [QB+1];
    logic [SIDE_W-1:0]   r_side [QB+1];
    logic [QB:0]         r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[QB-1:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= XW'(i_num[k]);
            end
            r_q[0]    <= '0;
            r_d[0]    <= XW'(i_den);
            r_neg[0]  <= i_neg;
            r_ovf[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int B = QB - 1 - j;
        logic [XW-1:0] w_sh;
        assign w_sh = r_d[j] << B;

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[j][k] >= w_sh) begin
                        r_rem[j+1][k] <= r_rem[j][k] - w_sh;
                        r_q[j+1][k]   <= r_q[j][k] | (QB'(1) << B);
                    end else begin
                        r_rem[j+1][k] <= r_rem[j][k];
                        r_q[j+1][k]   <= r_q[j][k];
                    end
                end
                if (j == 0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_ovf[j+1][k] <= r_rem[j][k] >= (r_d[j] << QB);
                    end
                end else begin
                    r_ovf[j+1] <= r_ovf[j];
                end
                r_d[j+1]    <= r_d[j];
                r_neg[j+1]  <= r_neg[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    always_comb begin
        logic [QB-1:0] mag;
        for (int k = 0; k < 3; k++) begin
            mag = r_ovf[QB][k] ? {QB{1'b1}} : r_q[QB][k];
            o_quot[k] = r_neg[QB][k] ? ((QB+1)'(0) - {1'b0, mag}) : {1'b0, mag};
        end
    end

    assign o_valid = r_v[QB];
    assign o_side  = r_side[QB];

endmodule

// ----- rtl/sphere_triangle_contact_core.sv -----
// top level of the sphere triangle contact core
// Finds the point of a triangle closest to a sphere center through the Voronoi
// region tests (vertex A, vertex B, edge AB, vertex C, edge AC, edge BC,
// interior), flags a hit when that point lies within the radius, and on a hit
// returns the closest point and the push-out vector along the face normal.
// Positions are signed fixed point of COORD_WIDTH bits per lane, the normal is
// signed Q1.14; lanes pack x, y, z from the low end. One query is taken every
// cycle while the result side does not stall; the path is eight arithmetic
// stages, the output register and a restoring divider of COORD_WIDTH + 3 stages
// (an input register, then one quotient bit per stage). A stall on the result
// side holds the whole pipeline.
module sphere_triangle_contact_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stc_in_if.sink    i_in,
    stc_out_if.source o_out
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int NW     = stc_pkg::NORM_W;
    localparam int NF     = stc_pkg::NORM_FRAC;
    localparam int DOTW   = 2 * DW + 2;
    localparam int PRW    = 2 * DOTW;
    localparam int VW     = PRW + 1;
    localparam int EW     = VW + DW;
    localparam int NUMW   = EW + 1;
    localparam int DENW   = VW + 2;
    localparam int RW     = NUMW + 2;
    localparam int QB     = CW + 2;
    localparam int SW     = QB + 3;
    localparam int LENW   = DW + NW + 3;
    localparam int PPW    = NW + LENW;
    localparam int SQW    = 2 * DW + 2;
    localparam int RRW    = 2 * (CW - 1);
    localparam int SH     = 2 * NF;
    localparam int SIDE_W = 3 + 1 + 9 * CW + (CW - 1);
    localparam int MLO    = VW / 2;
    localparam int MHW    = VW - MLO;
    localparam int PHW    = MHW + DW;
    localparam int PLW    = MLO + 1 + DW;

    function automatic logic [CW-1:0] sat_q(input logic signed [SW-1:0] v);
        if (v[SW-1:CW-1] == '0 || v[SW-1:CW-1] == '1) begin
            return v[CW-1:0];
        end
        return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    function automatic logic [CW-1:0] sat_p(input logic signed [PPW:0] v);
        if (v[PPW:CW-1] == '0 || v[PPW:CW-1] == '1) begin
            return v[CW-1:0];
        end
        return v[PPW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_vo;
    logic w_v7;

    assign w_en       = !r_vo || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= w_v7;
            r_v8 <= r_v7;
            r_vo <= r_v8;
        end
    end

    // stage 1: unpack lanes
    logic signed [CW-1:0] r1_p [3];
    logic signed [CW-1:0] r1_a [3];
    logic signed [CW-1:0] r1_b [3];
    logic signed [CW-1:0] r1_c [3];
    logic signed [NW-1:0] r1_n [3];
    logic [CW-2:0]        r1_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_p[k] <= i_in.sphere_center[k*CW +: CW];
                r1_a[k] <= i_in.vertex_a[k*CW +: CW];
                r1_b[k] <= i_in.vertex_b[k*CW +: CW];
                r1_c[k] <= i_in.vertex_c[k*CW +: CW];
                r1_n[k] <= i_in.face_normal[k*NW +: NW];
            end
            r1_r <= i_in.sphere_radius;
        end
    end

    // stage 2: edge vectors and dot products
    logic signed [DW-1:0]   n2_ab [3];
    logic signed [DW-1:0]   n2_ac [3];
    logic signed [DW-1:0]   n2_bc [3];
    logic signed [DW-1:0]   n2_ap [3];
    logic signed [DW-1:0]   n2_bp [3];
    logic signed [DW-1:0]   n2_cp [3];
    logic signed [DW-1:0]   n2_pa [3];
    logic signed [DOTW-1:0] n2_d  [6];
    logic signed [LENW-1:0] n2_len;
    logic signed [LENW-1:0] n2_rs;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_ab[k] = DW'(r1_b[k]) - DW'(r1_a[k]);
            n2_ac[k] = DW'(r1_c[k]) - DW'(r1_a[k]);
            n2_bc[k] = DW'(r1_c[k]) - DW'(r1_b[k]);
            n2_ap[k] = DW'(r1_p[k]) - DW'(r1_a[k]);
            n2_bp[k] = DW'(r1_p[k]) - DW'(r1_b[k]);
            n2_cp[k] = DW'(r1_p[k]) - DW'(r1_c[k]);
            n2_pa[k] = DW'(r1_a[k]) - DW'(r1_p[k]);
        end
        n2_d[0] = n2_ab[0] * n2_ap[0] + n2_ab[1] * n2_ap[1] + n2_ab[2] * n2_ap[2];
        n2_d[1] = n2_ac[0] * n2_ap[0] + n2_ac[1] * n2_ap[1] + n2_ac[2] * n2_ap[2];
        n2_d[2] = n2_ab[0] * n2_bp[0] + n2_ab[1] * n2_bp[1] + n2_ab[2] * n2_bp[2];
        n2_d[3] = n2_ac[0] * n2_bp[0] + n2_ac[1] * n2_bp[1] + n2_ac[2] * n2_bp[2];
        n2_d[4] = n2_ab[0] * n2_cp[0] + n2_ab[1] * n2_cp[1] + n2_ab[2] * n2_cp[2];
        n2_d[5] = n2_ac[0] * n2_cp[0] + n2_ac[1] * n2_cp[1] + n2_ac[2] * n2_cp[2];
        n2_rs   = LENW'($signed({1'b0, r1_r})) <<< NF;
        n2_len  = n2_pa[0] * r1_n[0] + n2_pa[1] * r1_n[1] + n2_pa[2] * r1_n[2] + n2_rs;
    end

    logic signed [DOTW-1:0] r2_d  [6];
    logic signed [LENW-1:0] r2_len;
    logic signed [DW-1:0]   r2_ab [3];
    logic signed [DW-1:0]   r2_ac [3];
    logic signed [DW-1:0]   r2_bc [3];
    logic signed [CW-1:0]   r2_a  [3];
    logic signed [CW-1:0]   r2_b  [3];
    logic signed [CW-1:0]   r2_c  [3];
    logic signed [CW-1:0]   r2_p  [3];
    logic signed [NW-1:0]   r2_n  [3];
    logic [CW-2:0]          r2_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d   <= n2_d;
            r2_len <= n2_len;
            r2_ab  <= n2_ab;
            r2_ac  <= n2_ac;
            r2_bc  <= n2_bc;
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_c   <= r1_c;
            r2_p   <= r1_p;
            r2_n   <= r1_n;
            r2_r   <= r1_r;
        end
    end

    // stage 3: cross products of the dot terms
    logic signed [PRW-1:0]  r3_pr [6];
    logic signed [DOTW-1:0] r3_d  [6];
    logic signed [LENW-1:0] r3_len;
    logic signed [DW-1:0]   r3_ab [3];
    logic signed [DW-1:0]   r3_ac [3];
    logic signed [DW-1:0]   r3_bc [3];
    logic signed [CW-1:0]   r3_a  [3];
    logic signed [CW-1:0]   r3_b  [3];
    logic signed [CW-1:0]   r3_c  [3];
    logic signed [CW-1:0]   r3_p  [3];
    logic signed [NW-1:0]   r3_n  [3];
    logic [CW-2:0]          r3_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pr[0] <= r2_d[0] * r2_d[3];
            r3_pr[1] <= r2_d[2] * r2_d[1];
            r3_pr[2] <= r2_d[4] * r2_d[1];
            r3_pr[3] <= r2_d[0] * r2_d[5];
            r3_pr[4] <= r2_d[2] * r2_d[5];
            r3_pr[5] <= r2_d[4] * r2_d[3];
            r3_d     <= r2_d;
            r3_len   <= r2_len;
            r3_ab    <= r2_ab;
            r3_ac    <= r2_ac;
            r3_bc    <= r2_bc;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_c     <= r2_c;
            r3_p     <= r2_p;
            r3_n     <= r2_n;
            r3_r     <= r2_r;
        end
    end

    // stage 4: region decision and divide operand selection
    logic signed [VW-1:0]     n4_va, n4_vb, n4_vc;
    logic signed [DOTW:0]     n4_d43, n4_d56, n4_d13, n4_d26;
    logic signed [DOTW+1:0]   n4_de;
    logic signed [DENW-1:0]   n4_dsum;
    logic signed [VW-1:0]     n4_m1, n4_m2;
    logic signed [DW-1:0]     n4_e1 [3];
    logic signed [DW-1:0]     n4_e2 [3];
    logic signed [DENW-1:0]   n4_den;
    logic [2:0][CW-1:0]       n4_base;
    logic                     n4_take;
    stc_pkg::t_region         n4_region;
    logic signed [PPW-1:0]    n4_pp [3];

    always_comb begin
        n4_vc   = VW'(r3_pr[0]) - VW'(r3_pr[1]);
        n4_vb   = VW'(r3_pr[2]) - VW'(r3_pr[3]);
        n4_va   = VW'(r3_pr[4]) - VW'(r3_pr[5]);
        n4_d43  = (DOTW+1)'(r3_d[3]) - (DOTW+1)'(r3_d[2]);
        n4_d56  = (DOTW+1)'(r3_d[4]) - (DOTW+1)'(r3_d[5]);
        n4_d13  = (DOTW+1)'(r3_d[0]) - (DOTW+1)'(r3_d[2]);
        n4_d26  = (DOTW+1)'(r3_d[1]) - (DOTW+1)'(r3_d[5]);
        n4_de   = (DOTW+2)'(n4_d43) + (DOTW+2)'(n4_d56);
        n4_dsum = DENW'(n4_va) + DENW'(n4_vb) + DENW'(n4_vc);
        for (int k = 0; k < 3; k++) begin
            n4_pp[k]   = PPW'(r3_n[k]) * PPW'(r3_len);
            n4_base[k] = r3_a[k];
        end
        n4_m1     = '0;
        n4_m2     = '0;
        n4_e1     = r3_ab;
        n4_e2     = r3_ac;
        n4_den    = DENW'(1);
        n4_take   = 1'b1;
        n4_region = stc_pkg::REG_IN;
        if (r3_d[0] <= 0 && r3_d[1] <= 0) begin
            n4_region = stc_pkg::REG_A;
        end else if (r3_d[2] >= 0 && r3_d[3] <= r3_d[2]) begin
            n4_region = stc_pkg::REG_B;
            for (int k = 0; k < 3; k++) n4_base[k] = r3_b[k];
        end else if (n4_vc <= 0 && r3_d[0] >= 0 && r3_d[2] <= 0) begin
            n4_region = stc_pkg::REG_AB;
            n4_m1     = VW'(r3_d[0]);
            n4_den    = DENW'(n4_d13);
            n4_take   = (n4_d13 == 0);
        end else if (r3_d[5] >= 0 && r3_d[4] <= r3_d[5]) begin
            n4_region = stc_pkg::REG_C;
            for (int k = 0; k < 3; k++) n4_base[k] = r3_c[k];
        end else if (n4_vb <= 0 && r3_d[1] >= 0 && r3_d[5] <= 0) begin
            n4_region = stc_pkg::REG_AC;
            n4_m1     = VW'(r3_d[1]);
            n4_e1     = r3_ac;
            n4_den    = DENW'(n4_d26);
            n4_take   = (n4_d26 == 0);
        end else if (n4_va <= 0 && n4_d43 >= 0 && n4_d56 >= 0) begin
            n4_region = stc_pkg::REG_BC;
            n4_m1     = VW'(n4_d43);
            n4_e1     = r3_bc;
            n4_den    = DENW'(n4_de);
            n4_take   = (n4_de == 0);
            for (int k = 0; k < 3; k++) n4_base[k] = r3_b[k];
        end else begin
            n4_m1   = n4_vb;
            n4_m2   = n4_vc;
            n4_den  = n4_dsum;
            n4_take = (n4_dsum <= 0);
        end
    end

    logic signed [VW-1:0]   r4_m1, r4_m2;
    logic signed [DW-1:0]   r4_e1 [3];
    logic signed [DW-1:0]   r4_e2 [3];
    logic signed [DENW-1:0] r4_den;
    logic [2:0][CW-1:0]     r4_base;
    logic                   r4_take;
    stc_pkg::t_region       r4_region;
    logic signed [PPW-1:0]  r4_pp [3];
    logic [2:0][CW-1:0]     r4_p;
    logic [CW-2:0]          r4_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_m1     <= n4_m1;
            r4_m2     <= n4_m2;
            r4_e1     <= n4_e1;
            r4_e2     <= n4_e2;
            r4_den    <= n4_den;
            r4_base   <= n4_base;
            r4_take   <= n4_take;
            r4_region <= n4_region;
            r4_pp     <= n4_pp;
            for (int k = 0; k < 3; k++) r4_p[k] <= r3_p[k];
            r4_r      <= r3_r;
        end
    end

    // stage 5: numerator partial products and push rounding
    logic [PPW-1:0]       n5_pmag [3];
    logic [PPW-1:0]       n5_prnd [3];
    logic signed [PPW:0]  n5_pval [3];
    logic [2:0][CW-1:0]   n5_push;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n5_pmag[k] = r4_pp[k][PPW-1] ? PPW'(-r4_pp[k]) : PPW'(r4_pp[k]);
            n5_prnd[k] = (n5_pmag[k] + (PPW'(1) << (SH - 1))) >> SH;
            n5_pval[k] = r4_pp[k][PPW-1] ? -$signed({1'b0, n5_prnd[k]})
                                         : $signed({1'b0, n5_prnd[k]});
            n5_push[k] = sat_p(n5_pval[k]);
        end
    end

    logic signed [PHW-1:0]  r5_p1h [3];
    logic signed [PLW-1:0]  r5_p1l [3];
    logic signed [PHW-1:0]  r5_p2h [3];
    logic signed [PLW-1:0]  r5_p2l [3];
    logic signed [DENW-1:0] r5_den;
    logic [2:0][CW-1:0]     r5_base;
    logic                   r5_take;
    stc_pkg::t_region       r5_region;
    logic [2:0][CW-1:0]     r5_push;
    logic [2:0][CW-1:0]     r5_p;
    logic [CW-2:0]          r5_r;

    // multiplier split into high signed and low unsigned halves
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r5_p1h[k] <= PHW'($signed(r4_m1[VW-1:MLO])) * PHW'(r4_e1[k]);
                r5_p1l[k] <= PLW'($signed({1'b0, r4_m1[MLO-1:0]})) * PLW'(r4_e1[k]);
                r5_p2h[k] <= PHW'($signed(r4_m2[VW-1:MLO])) * PHW'(r4_e2[k]);
                r5_p2l[k] <= PLW'($signed({1'b0, r4_m2[MLO-1:0]})) * PLW'(r4_e2[k]);
            end
            r5_den    <= r4_den;
            r5_base   <= r4_base;
            r5_take   <= r4_take;
            r5_region <= r4_region;
            r5_push   <= n5_push;
            r5_p      <= r4_p;
            r5_r      <= r4_r;
        end
    end

    // stage 6: numerator sum
    logic signed [NUMW-1:0] r6_num [3];
    logic signed [DENW-1:0] r6_den;
    logic [2:0][CW-1:0]     r6_base;
    logic                   r6_take;
    stc_pkg::t_region       r6_region;
    logic [2:0][CW-1:0]     r6_push;
    logic [2:0][CW-1:0]     r6_p;
    logic [CW-2:0]          r6_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r6_num[k] <= (NUMW'(r5_p1h[k]) <<< MLO) + NUMW'(r5_p1l[k])
                           + (NUMW'(r5_p2h[k]) <<< MLO) + NUMW'(r5_p2l[k]);
            end
            r6_den    <= r5_den;
            r6_base   <= r5_base;
            r6_take   <= r5_take;
            r6_region <= r5_region;
            r6_push   <= r5_push;
            r6_p      <= r5_p;
            r6_r      <= r5_r;
        end
    end

    // rounded division: (2|num| + den) / (2 den)
    logic [2:0][RW-1:0]   w_dnum;
    logic [2:0]           w_dneg;
    logic [DENW-1:0]      w_dden;
    logic [NUMW-1:0]      w_mag [3];
    logic [SIDE_W-1:0]    w_side_in, w_side_out;
    logic [2:0][QB:0]     w_quot;
    stc_pkg::t_stage_ctl  w_div_ctl;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dneg[k] = r6_num[k][NUMW-1];
            w_mag[k]  = w_dneg[k] ? NUMW'(-r6_num[k]) : NUMW'(r6_num[k]);
            w_dnum[k] = RW'({w_mag[k], 1'b0}) + RW'(r6_den[DENW-2:0]);
        end
        w_dden = {r6_den[DENW-2:0], 1'b0};
    end

    assign w_side_in = {r6_region, r6_take, r6_base, r6_p, r6_push, r6_r};
    assign w_div_ctl = '{en: w_en, valid: r_v6};

    stc_div #(
        .RW     (RW),
        .DNW    (DENW),
        .QB     (QB),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .i_neg   (w_dneg),
        .i_side  (w_side_in),
        .o_valid (w_v7),
        .o_quot  (w_quot),
        .o_side  (w_side_out)
    );

    // stage 7: closest point
    logic [2:0]           u_region;
    logic                 u_take;
    logic [2:0][CW-1:0]   u_base, u_p, u_push;
    logic [CW-2:0]        u_r;
    logic signed [SW-1:0] n7_sum [3];
    logic [2:0][CW-1:0]   n7_q;

    assign {u_region, u_take, u_base, u_p, u_push, u_r} = w_side_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n7_sum[k] = SW'($signed(u_base[k])) + SW'($signed(w_quot[k]));
            n7_q[k]   = u_take ? u_base[k] : sat_q(n7_sum[k]);
        end
    end

    logic [2:0][CW-1:0] r7_q, r7_p, r7_push;
    logic [CW-2:0]      r7_r;
    stc_pkg::t_region   r7_region;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_q      <= n7_q;
            r7_p      <= u_p;
            r7_push   <= u_push;
            r7_r      <= u_r;
            r7_region <= stc_pkg::t_region'(u_region);
        end
    end

    // stage 8: squared distance terms
    logic signed [DW-1:0] n8_diff [3];
    logic signed [2*DW-1:0] n8_sq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n8_diff[k] = DW'($signed(r7_q[k])) - DW'($signed(r7_p[k]));
            n8_sq[k]   = n8_diff[k] * n8_diff[k];
        end
    end

    logic [2*DW-1:0]    r8_sq [3];
    logic [RRW-1:0]     r8_rr;
    logic [2:0][CW-1:0] r8_q, r8_push;
    stc_pkg::t_region   r8_region;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) r8_sq[k] <= n8_sq[k];
            r8_rr     <= RRW'(r7_r) * RRW'(r7_r);
            r8_q      <= r7_q;
            r8_push   <= r7_push;
            r8_region <= r7_region;
        end
    end

    // output register
    logic [SQW-1:0]     w_dist;
    logic               w_hit;
    logic               r_o_hit;
    logic [3*CW-1:0]    r_o_cp, r_o_pv;
    stc_pkg::t_region   r_o_region;

    assign w_dist = SQW'(r8_sq[0]) + SQW'(r8_sq[1]) + SQW'(r8_sq[2]);
    assign w_hit  = w_dist <= SQW'(r8_rr);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_hit    <= w_hit;
            r_o_cp     <= w_hit ? r8_q : '0;
            r_o_pv     <= w_hit ? r8_push : '0;
            r_o_region <= r8_region;
        end
    end

    assign o_out.valid         = r_vo;
    assign o_out.hit           = r_o_hit;
    assign o_out.closest_point = r_o_cp;
    assign o_out.push_vector   = r_o_pv;
    assign o_out.region        = r_o_region;

endmodule
